[rtl/ezr_pkg.sv]
// ----------------------------------------------------------------------------
// ezr_pkg: shared definitions of the Euler z-x-z rotation unit
// Default field widths, fixed-point constants, the series divisor tables with
// their reciprocals, and the types shared by the rotation core and the
// sine/cosine pipeline.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 32;

  localparam int PHASE_W = 32;
  localparam int Q_FRAC = 30;
  localparam int TRIG_W = 32;
  localparam int MAT_W = 33;

  localparam logic [30:0] Q_ONE = 31'h4000_0000;
  localparam logic [30:0] Q_HALF = 31'h2000_0000;
  localparam logic [30:0] PI_HALF_Q30 = 31'h6487_ED51;

  localparam int HORNER_STEPS = 6;
  localparam int SIN_LANE = 0;
  localparam int COS_LANE = 1;

  // Divisors of the series terms; the last sine entry is the closing product by x.
  localparam logic [7:0] HORNER_DIV [2][HORNER_STEPS] = '{
    '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1},
    '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2}
  };

  // floor(2^32 / divisor); the closing sine entry is unused and zero.
  localparam logic [31:0] HORNER_RECIP [2][HORNER_STEPS] = '{
    '{32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882,
      32'd0},
    '{32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941,
      32'd2147483648}
  };

  // Register stages of the sine/cosine pipeline, input register included.
  localparam int SC_LAT = 3 + 3 * HORNER_STEPS + 1;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quadrant_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } sincos_t;

endpackage

[rtl/ezr_if.sv]
// ----------------------------------------------------------------------------
// ezr_if: stream channels of the Euler z-x-z rotation unit
// Valid/ready channels for the input beat (vector, angles, operation) and the
// result beat (rotated vector and saturation flag).
// ----------------------------------------------------------------------------
interface ezr_in_if #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [COORD_WIDTH-1:0] vec_x;
  logic signed [COORD_WIDTH-1:0] vec_y;
  logic signed [COORD_WIDTH-1:0] vec_z;
  logic [ANGLE_WIDTH-1:0]        angle_precession;
  logic [ANGLE_WIDTH-1:0]        angle_nutation;
  logic [ANGLE_WIDTH-1:0]        angle_spin;

  modport source (
    output valid, operation, vec_x, vec_y, vec_z,
    output angle_precession, angle_nutation, angle_spin,
    input ready
  );
  modport sink (
    input valid, operation, vec_x, vec_y, vec_z,
    input angle_precession, angle_nutation, angle_spin,
    output ready
  );
endinterface

interface ezr_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rot_x;
  logic signed [COORD_WIDTH-1:0] rot_y;
  logic signed [COORD_WIDTH-1:0] rot_z;
  logic                          clipped;

  modport source (output valid, rot_x, rot_y, rot_z, clipped, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, clipped, output ready);
endinterface

[rtl/ezr_sincos.sv]
// ----------------------------------------------------------------------------
// ezr_sincos: pipelined sine and cosine of a turn-fraction phase
// Octant folding, conversion to radians, and Horner evaluation of the Taylor
// series with three register stages per term, in Q30.
// ----------------------------------------------------------------------------
module ezr_sincos
  import ezr_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [PHASE_W-1:0] phase,
  output sincos_t            result
);

  localparam int LAST = SC_LAT - 2;

  logic [29:0] rr;
  logic [29:0] r_in;
  logic        fold;
  logic [30:0] folded;
  logic [60:0] x_full;
  logic [60:0] x2_full;

  quadrant_t   quad_p [0:LAST];
  logic        swp_p [0:LAST];
  logic [29:0] x_p [1:LAST];
  logic [29:0] x2_p [2:LAST];

  logic [30:0] pa_r [2][HORNER_STEPS];
  logic [30:0] pb_r [2][HORNER_STEPS];
  logic [30:0] qe_r [2][HORNER_STEPS];
  logic [30:0] t_r [2][HORNER_STEPS];

  logic [30:0] t_in [2][HORNER_STEPS];
  logic [29:0] mop [2][HORNER_STEPS];
  logic        fin [2][HORNER_STEPS];
  logic [61:0] prod [2][HORNER_STEPS];
  logic [62:0] qprod [2][HORNER_STEPS];
  logic [31:0] rem [2][HORNER_STEPS];
  logic [30:0] t_next [2][HORNER_STEPS];

  logic signed [TRIG_W-1:0] s0;
  logic signed [TRIG_W-1:0] c0;
  sincos_t                  res_next;
  sincos_t                  res_r;

  assign r_in = phase[29:0];
  assign fold = {1'b0, r_in} > Q_HALF;
  assign folded = Q_ONE - {1'b0, r_in};
  assign x_full = 61'(rr) * 61'(PI_HALF_Q30) + 61'(Q_HALF);
  assign x2_full = 61'(x_p[1]) * 61'(x_p[1]) + 61'(Q_HALF);

  always_comb begin
    for (int ln = 0; ln < 2; ln++) begin
      for (int k = 0; k < HORNER_STEPS; k++) begin
        fin[ln][k] = (ln == SIN_LANE) && (k == HORNER_STEPS - 1);
        t_in[ln][k] = (k == 0) ? Q_ONE : t_r[ln][(k == 0) ? 0 : k - 1];
        mop[ln][k] = fin[ln][k] ? x_p[2 + 3 * k] : x2_p[2 + 3 * k];
        prod[ln][k] = 62'(mop[ln][k]) * 62'(t_in[ln][k]) + 62'(Q_HALF);
        qprod[ln][k] = 63'(pa_r[ln][k]) * 63'(HORNER_RECIP[ln][k]);
        rem[ln][k] = 32'(pb_r[ln][k]) - 32'(qe_r[ln][k]) * 32'(HORNER_DIV[ln][k]);
        if (fin[ln][k]) begin
          t_next[ln][k] = qe_r[ln][k];
        end else if (rem[ln][k] >= 32'(HORNER_DIV[ln][k])) begin
          t_next[ln][k] = Q_ONE - (qe_r[ln][k] + 31'd1);
        end else begin
          t_next[ln][k] = Q_ONE - qe_r[ln][k];
        end
      end
    end
  end

  always_comb begin
    if (swp_p[LAST]) begin
      s0 = $signed({1'b0, t_r[COS_LANE][HORNER_STEPS-1]});
      c0 = $signed({1'b0, t_r[SIN_LANE][HORNER_STEPS-1]});
    end else begin
      s0 = $signed({1'b0, t_r[SIN_LANE][HORNER_STEPS-1]});
      c0 = $signed({1'b0, t_r[COS_LANE][HORNER_STEPS-1]});
    end
    unique case (quad_p[LAST])
      QUAD_0: begin
        res_next.s = s0;
        res_next.c = c0;
      end
      QUAD_1: begin
        res_next.s = c0;
        res_next.c = -s0;
      end
      QUAD_2: begin
        res_next.s = -s0;
        res_next.c = -c0;
      end
      QUAD_3: begin
        res_next.s = -c0;
        res_next.c = s0;
      end
      default: begin
        res_next.s = s0;
        res_next.c = c0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr <= fold ? folded[29:0] : r_in;
      quad_p[0] <= quadrant_t'(phase[31:30]);
      swp_p[0] <= fold;
      for (int i = 1; i <= LAST; i++) begin
        quad_p[i] <= quad_p[i-1];
        swp_p[i] <= swp_p[i-1];
      end
      x_p[1] <= x_full[59:30];
      for (int i = 2; i <= LAST; i++) begin
        x_p[i] <= x_p[i-1];
      end
      x2_p[2] <= x2_full[59:30];
      for (int i = 3; i <= LAST; i++) begin
        x2_p[i] <= x2_p[i-1];
      end
      for (int ln = 0; ln < 2; ln++) begin
        for (int k = 0; k < HORNER_STEPS; k++) begin
          pa_r[ln][k] <= prod[ln][k][60:30];
          pb_r[ln][k] <= pa_r[ln][k];
          qe_r[ln][k] <= fin[ln][k] ? pa_r[ln][k] : qprod[ln][k][62:32];
          t_r[ln][k] <= t_next[ln][k];
        end
      end
      res_r <= res_next;
    end
  end

  assign result = res_r;

endmodule

[rtl/euler_zxz_rotation_unit.sv]
// ----------------------------------------------------------------------------
// euler_zxz_rotation_unit: rotates a Q3.28 vector by z-x-z Euler angles
// Each input beat carries a vector, the precession, nutation and spin angles
// as fractions of a full turn, and an operation bit: 0 applies the rotation,
// 1 applies its transpose. Each input beat yields exactly one result beat with
// the rotated vector, saturated to the coordinate range, and a clipped flag.
// The unit is a single pipeline of 28 register stages: 22 for the sine and
// cosine pipelines of the three angles, three for the matrix products and
// three for the vector product and saturation. One beat is accepted per cycle
// while the output is not stalled.
// All stages advance together: when a result is held on the output and the
// receiver is not ready, the whole pipeline stalls and input ready drops,
// so nothing is lost or repeated. Empty stages are not squeezed out meanwhile.
// Synchronous reset clears all valid bits and holds input ready low; no
// result is pending afterwards.
// ----------------------------------------------------------------------------
module euler_zxz_rotation_unit
  import ezr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  ezr_in_if.sink    vec_in,
  ezr_out_if.source vec_out
);

  localparam int LAT = SC_LAT + 6;
  localparam int SPLIT = COORD_WIDTH / 2;
  localparam int PL_W = MAT_W + SPLIT + 1;
  localparam int PH_W = MAT_W + COORD_WIDTH - SPLIT;
  localparam int SA_W = PL_W + 2;
  localparam int SB_W = PH_W + 2;
  localparam int ACC_W = COORD_WIDTH + 37;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (Q_FRAC - 1);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  function automatic logic signed [MAT_W-1:0] smul(
    input logic signed [MAT_W-1:0] a,
    input logic signed [MAT_W-1:0] b
  );
    logic [MAT_W-1:0]     ma;
    logic [MAT_W-1:0]     mb;
    logic [2*MAT_W-1:0]   p;
    logic                 neg;
    logic signed [MAT_W-1:0] m;
    neg = a[MAT_W-1] ^ b[MAT_W-1];
    ma = a[MAT_W-1] ? MAT_W'(-a) : MAT_W'(a);
    mb = b[MAT_W-1] ? MAT_W'(-b) : MAT_W'(b);
    p = (2*MAT_W)'(ma) * (2*MAT_W)'(mb) + (2*MAT_W)'(Q_HALF);
    m = $signed(p[Q_FRAC+MAT_W-1:Q_FRAC]);
    return neg ? -m : m;
  endfunction

  logic                   en;
  logic [LAT-1:0]         vld;
  logic [PHASE_W-1:0]     phase [3];
  logic [ANGLE_WIDTH-1:0] angle [3];
  sincos_t                sc [3];

  logic                          op_p [SC_LAT];
  logic signed [COORD_WIDTH-1:0] v_p [SC_LAT][3];

  logic signed [MAT_W-1:0] p1_r [8];
  logic signed [MAT_W-1:0] p2_r [8];
  logic signed [MAT_W-1:0] tt_r [4];
  logic signed [MAT_W-1:0] cth1;
  logic signed [MAT_W-1:0] cth2;
  logic                    op1;
  logic                    op2;
  logic signed [COORD_WIDTH-1:0] v1 [3];
  logic signed [COORD_WIDTH-1:0] v2 [3];
  logic signed [COORD_WIDTH-1:0] v3 [3];

  logic signed [MAT_W-1:0] sphi, cphi, sth, cth, spsi, cpsi;
  logic signed [MAT_W-1:0] f [3][3];
  logic signed [MAT_W-1:0] m_r [3][3];
  logic signed [PL_W-1:0]  pl_r [3][3];
  logic signed [PH_W-1:0]  ph_r [3][3];
  logic signed [SA_W-1:0]  sa_r [3];
  logic signed [SB_W-1:0]  sb_r [3];
  logic signed [ACC_W-1:0] tot [3];
  logic [ACC_W-Q_FRAC-COORD_WIDTH:0] hi [3];
  logic signed [COORD_WIDTH-1:0] rot_next [3];
  logic [2:0]                    ovf;
  logic signed [COORD_WIDTH-1:0] rot_r [3];
  logic                          clip_r;

  assign en = !vld[LAT-1] || vec_out.ready;
  assign vec_in.ready = en && !rst;

  assign angle[0] = vec_in.angle_precession;
  assign angle[1] = vec_in.angle_nutation;
  assign angle[2] = vec_in.angle_spin;

  for (genvar a = 0; a < 3; a++) begin : g_angle
    if (ANGLE_WIDTH >= PHASE_W) begin : g_trim
      assign phase[a] = angle[a][ANGLE_WIDTH-1 -: PHASE_W];
    end else begin : g_pad
      assign phase[a] = {angle[a], {(PHASE_W-ANGLE_WIDTH){1'b0}}};
    end
    ezr_sincos u_sincos (
      .clk    (clk),
      .en     (en),
      .phase  (phase[a]),
      .result (sc[a])
    );
  end

  assign sphi = MAT_W'(sc[0].s);
  assign cphi = MAT_W'(sc[0].c);
  assign sth  = MAT_W'(sc[1].s);
  assign cth  = MAT_W'(sc[1].c);
  assign spsi = MAT_W'(sc[2].s);
  assign cpsi = MAT_W'(sc[2].c);

  always_comb begin
    f[0][0] = p2_r[0] - tt_r[1];
    f[0][1] = p2_r[2] + tt_r[3];
    f[0][2] = p2_r[4];
    f[1][0] = -p2_r[3] - tt_r[2];
    f[1][1] = -p2_r[1] + tt_r[0];
    f[1][2] = p2_r[5];
    f[2][0] = p2_r[6];
    f[2][1] = -p2_r[7];
    f[2][2] = cth2;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (ACC_W'(sb_r[i]) <<< SPLIT) + ACC_W'(sa_r[i]) + ROUND_HALF;
      hi[i] = tot[i][ACC_W-1:Q_FRAC+COORD_WIDTH-1];
      ovf[i] = !((&hi[i]) || !(|hi[i]));
      if (ovf[i]) begin
        rot_next[i] = tot[i][ACC_W-1] ? COORD_MIN : COORD_MAX;
      end else begin
        rot_next[i] = tot[i][Q_FRAC+COORD_WIDTH-1:Q_FRAC];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], vec_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_p[0] <= vec_in.operation;
      v_p[0][0] <= vec_in.vec_x;
      v_p[0][1] <= vec_in.vec_y;
      v_p[0][2] <= vec_in.vec_z;
      for (int i = 1; i < SC_LAT; i++) begin
        op_p[i] <= op_p[i-1];
        v_p[i] <= v_p[i-1];
      end

      p1_r[0] <= smul(cpsi, cphi);
      p1_r[1] <= smul(sphi, spsi);
      p1_r[2] <= smul(cpsi, sphi);
      p1_r[3] <= smul(cphi, spsi);
      p1_r[4] <= smul(spsi, sth);
      p1_r[5] <= smul(cpsi, sth);
      p1_r[6] <= smul(sth, sphi);
      p1_r[7] <= smul(sth, cphi);
      cth1 <= cth;
      op1 <= op_p[SC_LAT-1];
      v1 <= v_p[SC_LAT-1];

      for (int i = 0; i < 4; i++) begin
        tt_r[i] <= smul(cth1, p1_r[i]);
      end
      p2_r <= p1_r;
      cth2 <= cth1;
      op2 <= op1;
      v2 <= v1;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m_r[i][j] <= op2 ? f[j][i] : f[i][j];
        end
      end
      v3 <= v2;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pl_r[i][j] <= PL_W'(m_r[i][j]) * PL_W'($signed({1'b0, v3[j][SPLIT-1:0]}));
          ph_r[i][j] <= PH_W'(m_r[i][j]) * PH_W'($signed(v3[j][COORD_WIDTH-1:SPLIT]));
        end
      end

      for (int i = 0; i < 3; i++) begin
        sa_r[i] <= SA_W'(pl_r[i][0]) + SA_W'(pl_r[i][1]) + SA_W'(pl_r[i][2]);
        sb_r[i] <= SB_W'(ph_r[i][0]) + SB_W'(ph_r[i][1]) + SB_W'(ph_r[i][2]);
      end

      rot_r <= rot_next;
      clip_r <= |ovf;
    end
  end

  assign vec_out.valid = vld[LAT-1];
  assign vec_out.rot_x = rot_r[0];
  assign vec_out.rot_y = rot_r[1];
  assign vec_out.rot_z = rot_r[2];
  assign vec_out.clipped = clip_r;

endmodule

[test/tb_euler_zxz_rotation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_zxz_rotation_unit: self-checking bench of the Euler z-x-z rotation
// Drives vectors and angle triples through the input channel with random
// gaps, stalls the result channel at random, and compares every result beat
// field by field with a bit-exact fixed-point rotation computed in the bench.
// Directed beats cover zero and quadrant angles, octant edges, field extremes
// and saturation; the bulk is random.
// ----------------------------------------------------------------------------
module tb_euler_zxz_rotation_unit;
  import ezr_pkg::*;

  localparam int CW = 32;
  localparam int AW = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam longint ONE_Q = longint'(1) << 30;
  localparam longint HALF_Q = longint'(1) << 29;
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef struct {
    logic                 op;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [AW-1:0]        phi;
    logic [AW-1:0]        theta;
    logic [AW-1:0]        psi;
  } rot_req_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 clipped;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  rot_res_t rotations_due[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;
  int stall_left = 0;

  ezr_in_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) vin ();
  ezr_out_if #(.COORD_WIDTH(CW)) vout ();

  euler_zxz_rotation_unit #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) dut (
    .clk(clk),
    .rst(rst),
    .vec_in(vin),
    .vec_out(vout)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned q30_round(longint unsigned a, longint unsigned b);
    return (a * b + HALF_Q) >> 30;
  endfunction

  function automatic longint q30_signed(longint a, longint b);
    longint unsigned ua, ub, m;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    m = (ua * ub + HALF_Q) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void octant_series(input longint unsigned r, output longint s,
                                        output longint c);
    longint unsigned x, x2, t;
    x = (r * longint'(PI_HALF_Q30) + HALF_Q) >> 30;
    x2 = q30_round(x, x);
    t = ONE_Q;
    for (int i = 0; i < 5; i++) t = ONE_Q - q30_round(x2, t) / HORNER_DIV[SIN_LANE][i];
    s = q30_round(x, t);
    t = ONE_Q;
    for (int i = 0; i < 6; i++) t = ONE_Q - q30_round(x2, t) / HORNER_DIV[COS_LANE][i];
    c = t;
  endfunction

  function automatic void turn_sincos(input logic [31:0] a, output longint s,
                                      output longint c);
    longint unsigned r;
    longint s0, c0;
    r = a[29:0];
    if (r > HALF_Q) octant_series(ONE_Q - r, c0, s0);
    else octant_series(r, s0, c0);
    case (quadrant_t'(a[31:30]))
      QUAD_0: begin s = s0; c = c0; end
      QUAD_1: begin s = c0; c = -s0; end
      QUAD_2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic longint row_dot(input longint m[3], input longint v[3]);
    longint lo, hi, vh, bq, br;
    lo = 0;
    hi = 0;
    for (int j = 0; j < 3; j++) begin
      vh = v[j] >>> 24;
      lo += m[j] * (v[j] - vh * 16777216);
      hi += m[j] * vh;
    end
    bq = hi >>> 6;
    br = hi - bq * 64;
    return bq + ((br * 16777216 + lo + HALF_Q) >>> 30);
  endfunction

  function automatic rot_res_t rotate_vector(rot_req_t q);
    longint sf, cf, st, ct, ss, cs, r;
    longint f[3][3];
    longint row[3];
    longint v[3];
    rot_res_t res;
    turn_sincos(q.phi, sf, cf);
    turn_sincos(q.theta, st, ct);
    turn_sincos(q.psi, ss, cs);
    v[0] = q.x;
    v[1] = q.y;
    v[2] = q.z;
    f[0][0] = q30_signed(cs, cf) - q30_signed(ct, q30_signed(sf, ss));
    f[0][1] = q30_signed(cs, sf) + q30_signed(ct, q30_signed(cf, ss));
    f[0][2] = q30_signed(ss, st);
    f[1][0] = -q30_signed(ss, cf) - q30_signed(ct, q30_signed(sf, cs));
    f[1][1] = -q30_signed(ss, sf) + q30_signed(ct, q30_signed(cf, cs));
    f[1][2] = q30_signed(cs, st);
    f[2][0] = q30_signed(st, sf);
    f[2][1] = -q30_signed(st, cf);
    f[2][2] = ct;
    res.clipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) row[j] = q.op ? f[j][i] : f[i][j];
      r = row_dot(row, v);
      if (r > COORD_MAX) begin r = COORD_MAX; res.clipped = 1'b1; end
      if (r < COORD_MIN) begin r = COORD_MIN; res.clipped = 1'b1; end
      if (i == 0) res.x = r;
      else if (i == 1) res.y = r;
      else res.z = r;
    end
    return res;
  endfunction

  function automatic int idle_gap();
    int p;
    p = $urandom_range(99);
    if (steady || p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_beat(rot_req_t q);
    int gap;
    vin.valid <= 1'b1;
    vin.operation <= q.op;
    vin.vec_x <= q.x;
    vin.vec_y <= q.y;
    vin.vec_z <= q.z;
    vin.angle_precession <= q.phi;
    vin.angle_nutation <= q.theta;
    vin.angle_spin <= q.psi;
    do @(negedge clk); while (!vin.ready);
    rotations_due.push_back(rotate_vector(q));
    @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic rot_req_t make_req(logic op, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [31:0] phi,
                                        logic [31:0] theta, logic [31:0] psi);
    rot_req_t q;
    q.op = op;
    q.x = x;
    q.y = y;
    q.z = z;
    q.phi = phi;
    q.theta = theta;
    q.psi = psi;
    return q;
  endfunction

  function automatic logic [31:0] rand_angle();
    logic [31:0] a;
    case ($urandom_range(3))
      0: a = {2'($urandom_range(3)), 30'h2000_0000 + 30'($urandom_range(4)) - 30'd2};
      1: a = {2'($urandom_range(3)), 30'($urandom_range(3))};
      default: a = $urandom;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(255) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_quadrants();
    logic [31:0] quarter[4] = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000};
    for (int i = 0; i < 4; i++) begin
      send_beat(make_req(1'b0, 32'h1000_0000, 32'h0800_0000, 32'hF000_0000,
                         quarter[i], quarter[(i + 1) % 4], quarter[(i + 2) % 4]));
      send_beat(make_req(1'b1, 32'h1000_0000, 32'h0800_0000, 32'hF000_0000,
                         quarter[i], quarter[(i + 1) % 4], quarter[(i + 2) % 4]));
    end
  endtask

  task automatic test_octant_edges();
    send_beat(make_req(1'b0, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000,
                       32'h2000_0000, 32'h2000_0001, 32'h1FFF_FFFF));
    send_beat(make_req(1'b1, 32'h0123_4567, 32'hFEDC_BA98, 32'h0F0F_0F0F,
                       32'h6000_0000, 32'hA000_0001, 32'hFFFF_FFFF));
    send_beat(make_req(1'b0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF));
  endtask

  task automatic test_extremes();
    send_beat(make_req(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h2000_0000, 32'h2000_0000, 32'h2000_0000));
    send_beat(make_req(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h2000_0000, 32'h6000_0000, 32'hE000_0000));
    send_beat(make_req(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0));
    send_beat(make_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_beat(make_req(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                       32'h1555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 0) steady = ($urandom_range(3) == 0);
      send_beat(make_req(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                         rand_angle(), rand_angle(), rand_angle()));
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      vout.ready <= 1'b0;
    end else if (!steady && $urandom_range(9) == 0) begin
      stall_left <= idle_gap();
      vout.ready <= 1'b0;
    end else begin
      vout.ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    rot_res_t want;
    if (!rst && vout.valid && vout.ready) begin
      if (rotations_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat x=%h y=%h z=%h c=%b",
                                       vout.rot_x, vout.rot_y, vout.rot_z, vout.clipped);
      end else begin
        want = rotations_due.pop_front();
        if (vout.rot_x !== want.x || vout.rot_y !== want.y || vout.rot_z !== want.z ||
            vout.clipped !== want.clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h z=%h c=%b, got x=%h y=%h z=%h c=%b",
                     want.x, want.y, want.z, want.clipped,
                     vout.rot_x, vout.rot_y, vout.rot_z, vout.clipped);
        end
      end
    end
    if ((vin.valid && vin.ready) || (vout.valid && vout.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    vin.valid = 1'b0;
    vin.operation = 1'b0;
    vin.vec_x = '0;
    vin.vec_y = '0;
    vin.vec_z = '0;
    vin.angle_precession = '0;
    vin.angle_nutation = '0;
    vin.angle_spin = '0;
    vout.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_quadrants();
    test_octant_edges();
    test_extremes();
    test_random(1000);
    vin.valid <= 1'b0;
    while (rotations_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && rotations_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
